/* rtl/sua_pkg.sv */
// ============================================================================
// sua_pkg: shared types and constants for the sorted unique address set
// Request/response payloads, status codes, the controller/datapath
// command and status groups, and the byte-order swap.
// ============================================================================
`default_nettype none

package sua_pkg;

    localparam int CAPACITY = 64;
    localparam int TBL_AW   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = 32;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_PRESENT = 3'd1,
        ST_FULL    = 3'd2,
        ST_READ_OK = 3'd3,
        ST_RANGE   = 3'd4
    } status_t;

    typedef struct packed {
        op_t                 op;
        logic [ADDR_W-1:0]   address;
        logic [INDEX_W-1:0]  index;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [ADDR_W-1:0]   entry_value;
        logic [COUNT_W-1:0]  entry_count;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic    capture;     // latch the accepted request
        logic    scan;        // walk the table for match / insert position
        logic    shift_init;  // start the move-up pass at the top entry
        logic    shift;       // move entries above the insert point up by one
        logic    place;       // write the new entry, bump the count
        logic    rd_index;    // read the entry at the requested index
        logic    load_out;    // load the response register
        status_t code;        // status of the response being loaded
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_read;
        logic scan_done;
        logic found;
        logic full;
        logic shift_done;
        logic idx_ok;
        logic out_free;
    } sts_t;

    function automatic logic [ADDR_W-1:0] swap_bytes(input logic [ADDR_W-1:0] w);
        swap_bytes = {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

`default_nettype wire

/* rtl/sorted_unique_address_set_top.sv */
// ============================================================================
// sorted_unique_address_set_top: sorted table of unique IPv4 addresses
// Add requests insert a byte-swapped address in ascending order unless it
// is already stored or the table is full; read requests return the entry at
// a sorted position, or ST_RANGE with a zero value past the stored count.
// ============================================================================
//
//  channel   payload       valid       stall       carries
//  -------   -----------   ---------   ---------   ------------------------------
//  request   req (req_t)   req_valid   req_stall   op, address, index
//  response  rsp (rsp_t)   rsp_valid   rsp_stall   status, entry_value, entry_count
//
//  One request is worked at a time. A read passes the start, read and finish states.
//  An add walks the table RAM once for the compare, then
//  moves the entries above the insert point up one place (one RAM read and
//  one write per cycle, pipelined); a duplicate or a full table skips the
//  move-up and the placement.
//  The single read port and single write port of the table RAM pace both passes.
//  Reset empties the table at once (count goes to zero); no clearing pass.
//  A new request is taken while an earlier response still waits under
//  rsp_stall; its response is loaded once the response register frees up.
// ============================================================================
`default_nettype none

module sorted_unique_address_set_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire sua_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output sua_pkg::rsp_t      rsp
);

    sua_pkg::cmd_t cmd;
    sua_pkg::sts_t sts;

    // sequencing: accept, scan, decide, move-up, place, index read, respond
    sua_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // table RAM, count, compare and response register
    sua_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

/* rtl/sua_ram.sv */
// ============================================================================
// sua_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds
// while no read is issued.
// ============================================================================
`default_nettype none

module sua_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/sua_dp.sv */
// ============================================================================
// sua_dp: datapath of the sorted unique address set
// Table RAM, entry count, scan pointer, compare logic, move-up pipeline
// and the response register.
// ============================================================================
`default_nettype none

module sua_dp (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire sua_pkg::req_t req,
    input  wire sua_pkg::cmd_t cmd,
    output sua_pkg::sts_t      sts,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output sua_pkg::rsp_t      rsp
);

    // control registers
    logic [sua_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                        cmp_valid_reg, cmp_valid_next;
    logic                        wr_pend_reg, wr_pend_next;
    logic                        rsp_valid_reg, rsp_valid_next;

    // payload registers
    sua_pkg::op_t                op_reg, op_next;
    logic [sua_pkg::ADDR_W-1:0]  host_reg, host_next;
    logic [sua_pkg::INDEX_W-1:0] index_reg, index_next;
    logic [sua_pkg::CNT_W-1:0]   ptr_reg, ptr_next;
    logic [sua_pkg::CNT_W-1:0]   pos_reg, pos_next;
    logic                        found_reg, found_next;
    logic [sua_pkg::TBL_AW-1:0]  wr_addr_reg, wr_addr_next;
    sua_pkg::rsp_t               rsp_reg, rsp_next;

    // RAM ports
    logic                        ram_wr_en;
    logic [sua_pkg::TBL_AW-1:0]  ram_wr_addr;
    logic [sua_pkg::ADDR_W-1:0]  ram_wr_data;
    logic                        ram_rd_en;
    logic [sua_pkg::TBL_AW-1:0]  ram_rd_addr;
    logic [sua_pkg::ADDR_W-1:0]  ram_rd_data;

    logic [sua_pkg::CNT_W-1:0]   ptr_dec;
    logic                        scan_issue;
    logic                        shift_issue;
    logic                        out_free;

    sua_ram #(
        .WIDTH (sua_pkg::ADDR_W),
        .DEPTH (sua_pkg::CAPACITY)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign ptr_dec     = ptr_reg - sua_pkg::CNT_W'(1);
    assign scan_issue  = cmd.scan && (ptr_reg != count_reg);
    assign shift_issue = cmd.shift && (ptr_reg != pos_reg);
    assign out_free    = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        count_next     = count_reg;
        cmp_valid_next = scan_issue;
        wr_pend_next   = shift_issue;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        op_next        = op_reg;
        host_next      = host_reg;
        index_next     = index_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        wr_addr_next   = wr_addr_reg;
        rsp_next       = rsp_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = wr_addr_reg;
        ram_wr_data    = ram_rd_data;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = ptr_reg[sua_pkg::TBL_AW-1:0];

        if (cmd.capture)
        begin
            op_next    = req.op;
            host_next  = sua_pkg::swap_bytes(req.address);
            index_next = req.index;
            ptr_next   = '0;
            pos_next   = '0;
            found_next = 1'b0;
        end

        // scan: read at ptr, compare in the next cycle
        if (scan_issue)
        begin
            ram_rd_en = 1'b1;
            ptr_next  = ptr_reg + sua_pkg::CNT_W'(1);
        end
        if (cmp_valid_reg)
        begin
            if (ram_rd_data == host_reg)
            begin
                found_next = 1'b1;
            end
            else if (ram_rd_data < host_reg)
            begin
                pos_next = pos_reg + sua_pkg::CNT_W'(1);
            end
        end

        if (cmd.shift_init)
        begin
            ptr_next = count_reg;
        end

        // move-up: read entry ptr-1, write it to ptr on the next cycle
        if (shift_issue)
        begin
            ram_rd_en    = 1'b1;
            ram_rd_addr  = ptr_dec[sua_pkg::TBL_AW-1:0];
            wr_addr_next = ptr_reg[sua_pkg::TBL_AW-1:0];
            ptr_next     = ptr_dec;
        end
        if (wr_pend_reg)
        begin
            ram_wr_en = 1'b1;
        end

        if (cmd.place)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_reg[sua_pkg::TBL_AW-1:0];
            ram_wr_data = host_reg;
            count_next  = count_reg + sua_pkg::CNT_W'(1);
        end

        if (cmd.rd_index)
        begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = sua_pkg::TBL_AW'(index_reg);
        end

        if (cmd.load_out)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.status      = cmd.code;
            rsp_next.entry_count = sua_pkg::COUNT_W'(count_reg);
            case (cmd.code)
                sua_pkg::ST_READ_OK: rsp_next.entry_value = ram_rd_data;
                sua_pkg::ST_RANGE:   rsp_next.entry_value = '0;
                default:             rsp_next.entry_value = host_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            wr_pend_reg   <= wr_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        host_reg    <= host_next;
        index_reg   <= index_next;
        ptr_reg     <= ptr_next;
        pos_reg     <= pos_next;
        found_reg   <= found_next;
        wr_addr_reg <= wr_addr_next;
        rsp_reg     <= rsp_next;
    end

    always_comb
    begin
        sts.is_read    = (op_reg == sua_pkg::OP_READ);
        sts.scan_done  = (ptr_reg == count_reg) && !cmp_valid_reg;
        sts.found      = found_reg;
        sts.full       = (count_reg == sua_pkg::CNT_W'(sua_pkg::CAPACITY));
        sts.shift_done = (ptr_reg == pos_reg) && !wr_pend_reg;
        sts.idx_ok     = (sua_pkg::CNT_W'(index_reg) < count_reg);
        sts.out_free   = out_free;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

/* rtl/sua_ctrl.sv */
// ============================================================================
// sua_ctrl: controller of the sorted unique address set
// Sequences scan, decision, move-up, placement, index read and the
// response load.
// ============================================================================
`default_nettype none

module sua_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire sua_pkg::sts_t sts,
    output sua_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_PLACE,
        S_READ,
        S_FINISH
    } state_t;

    state_t           state_reg, state_next;
    sua_pkg::status_t code_reg, code_next;

    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        cmd            = '0;
        cmd.code       = code_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                state_next = sts.is_read ? S_READ : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.found)
                begin
                    code_next  = sua_pkg::ST_PRESENT;
                    state_next = S_FINISH;
                end
                else if (sts.full)
                begin
                    code_next  = sua_pkg::ST_FULL;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.shift_init = 1'b1;
                    state_next     = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (sts.shift_done)
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                code_next  = sua_pkg::ST_ADDED;
                state_next = S_FINISH;
            end
            S_READ:
            begin
                cmd.rd_index = 1'b1;
                code_next    = sts.idx_ok ? sua_pkg::ST_READ_OK : sua_pkg::ST_RANGE;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= sua_pkg::ST_ADDED;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire
